// ===== rtl/mrct_pkg.sv =====
package mrct_pkg;

    localparam int MAC_W           = 48;
    localparam int MAX_ENTRIES_DEF = 8;
    // a list never emits more than this many items
    localparam int LIST_CAP        = 8;
    localparam int LCNT_W          = 4;

    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_LOOKUP   = 3'd1;
    localparam logic [2:0] CMD_LIST     = 3'd2;
    localparam logic [2:0] CMD_INIT     = 3'd3;
    localparam logic [2:0] CMD_DEINIT   = 3'd4;

    localparam logic [1:0] ROLE_UNKNOWN = 2'd0;
    localparam logic [1:0] ROLE_LEFT    = 2'd1;
    localparam logic [1:0] ROLE_RIGHT   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STATE = 2'd1;
    localparam logic [1:0] ST_ARG   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]       command;
        logic [MAC_W-1:0] client_mac;
        logic [1:0]       req_role;
        logic [3:0]       max_count;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [1:0]       role_out;
        logic [1:0]       available_role;
        logic [MAC_W-1:0] entry_mac;
        logic             entry_valid;
        logic             last;
    } t_result;

    typedef struct packed {
        logic             used;
        logic [MAC_W-1:0] mac;
        logic [1:0]       role;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic clr;
    } t_cell_ctl;

endpackage

// ===== rtl/mrct_cell.sv =====
module mrct_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrct_pkg::t_cell_ctl i_ctl,
    input  mrct_pkg::t_entry    i_next,
    output mrct_pkg::t_entry    o_entry
);

    mrct_pkg::t_entry r_entry;
    mrct_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.clr) begin
            n_entry = '0;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/mac_role_client_table.sv =====
// Client table of MAX_ENTRIES entries held in a ring of cells that rotates one
// place per cycle while a pass is under way; the controller only looks at the
// head cell. Init and deinit clear the ring at once and give their item in the
// cycle after acceptance, with busy staying low. Every other command first
// rotates the ring through one full pass to gather matches, free slots and held
// roles, then decides in S_DECIDE, where a register, a lookup and a list with
// nothing to show give their single result. A register that changes the table
// and a list that has entries to show keep busy high for a second pass; the
// write happens as the chosen entry passes the head, and list items come out
// in index order, one per used entry up to the capped max_count, during that
// pass. Results are strobed for one cycle and cannot be held off.
module mac_role_client_table #(
    parameter int MAX_ENTRIES = mrct_pkg::MAX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  mrct_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output mrct_pkg::t_result o_result
);

    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int LW   = mrct_pkg::LCNT_W;
    localparam int CMPW = (CW > LW) ? CW : LW;
    localparam logic [IW-1:0] CNT_LAST = IW'(MAX_ENTRIES - 1);
    localparam logic [LW-1:0] LIST_MAX = LW'(mrct_pkg::LIST_CAP);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_APPLY  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [2:0]                 r_cmd, n_cmd;
    logic [mrct_pkg::MAC_W-1:0] r_mac, n_mac;
    logic [1:0]                 r_req, n_req;
    logic [LW-1:0]              r_limit, n_limit;
    logic                       r_enabled, n_enabled;
    logic [IW-1:0]              r_cnt, n_cnt;
    logic                       r_found, n_found;
    logic [IW-1:0]              r_match_idx, n_match_idx;
    logic [1:0]                 r_match_role, n_match_role;
    logic                       r_free_ok, n_free_ok;
    logic [IW-1:0]              r_free_idx, n_free_idx;
    logic                       r_lo, n_lo;
    logic                       r_ro, n_ro;
    logic [CW-1:0]              r_nused, n_nused;
    logic                       r_wr, n_wr;
    logic [IW-1:0]              r_wr_idx, n_wr_idx;
    logic [LW-1:0]              r_total, n_total;
    logic [LW-1:0]              r_ecnt, n_ecnt;
    logic [1:0]                 r_avail, n_avail;
    logic                       r_strobe, n_strobe;
    mrct_pkg::t_result          r_result, n_result;

    mrct_pkg::t_entry    w_entry [MAX_ENTRIES];
    mrct_pkg::t_entry    w_head;
    mrct_pkg::t_entry    w_tail_feed;
    mrct_pkg::t_cell_ctl w_ctl;

    logic          w_accept;
    logic          w_head_match;
    logic          w_role_ok;
    logic          w_taken;
    logic [1:0]    d_status;
    logic          d_wr;
    logic [IW-1:0] d_wr_idx;
    logic          d_nr_valid;
    logic [1:0]    d_nr;
    logic          d_left;
    logic          d_right;
    logic [1:0]    d_avail;
    logic          d_found;
    logic [CMPW-1:0] d_nused_x;
    logic [LW-1:0] d_total;

    assign w_accept     = start && !busy;
    assign w_head       = w_entry[0];
    assign w_head_match = w_head.used && (w_head.mac == r_mac);

    // ring: the head re-enters at the tail, replaced by the new entry on a write
    always_comb begin
        w_tail_feed = w_head;
        if (r_state == S_APPLY && r_wr && r_cnt == r_wr_idx) begin
            w_tail_feed.used = 1'b1;
            w_tail_feed.mac  = r_mac;
            w_tail_feed.role = r_req;
        end
    end

    assign w_ctl.shift = (r_state == S_SCAN) || (r_state == S_APPLY);
    assign w_ctl.clr   = w_accept && (i_item.command == mrct_pkg::CMD_INIT ||
                                      i_item.command == mrct_pkg::CMD_DEINIT);

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        mrct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_next  ((g == MAX_ENTRIES - 1) ? w_tail_feed : w_entry[(g + 1) % MAX_ENTRIES]),
            .o_entry (w_entry[g])
        );
    end

    // decision after the gathering pass
    always_comb begin
        w_role_ok = (r_req == mrct_pkg::ROLE_LEFT) || (r_req == mrct_pkg::ROLE_RIGHT);
        w_taken   = (r_req == mrct_pkg::ROLE_LEFT) ? r_lo : r_ro;
        d_status  = mrct_pkg::ST_OK;
        d_wr      = 1'b0;
        d_wr_idx  = r_free_idx;
        if (r_cmd == mrct_pkg::CMD_REGISTER) begin
            if (!r_enabled) begin
                d_status = mrct_pkg::ST_STATE;
            end else if (!w_role_ok) begin
                d_status = mrct_pkg::ST_ARG;
            end else if (r_found) begin
                if (r_match_role != r_req) begin
                    if (w_taken) begin
                        d_status = mrct_pkg::ST_STATE;
                    end else begin
                        d_wr     = 1'b1;
                        d_wr_idx = r_match_idx;
                    end
                end
            end else if (!r_free_ok) begin
                d_status = mrct_pkg::ST_FULL;
            end else if (w_taken) begin
                d_status = mrct_pkg::ST_STATE;
            end else begin
                d_wr = 1'b1;
            end
        end
        // roles after the step: other entries plus the matched/written one
        d_nr_valid = d_wr || r_found;
        d_nr       = d_wr ? r_req : r_match_role;
        d_left     = r_lo || (d_nr_valid && d_nr == mrct_pkg::ROLE_LEFT);
        d_right    = r_ro || (d_nr_valid && d_nr == mrct_pkg::ROLE_RIGHT);
        if (!d_left) begin
            d_avail = mrct_pkg::ROLE_LEFT;
        end else if (!d_right) begin
            d_avail = mrct_pkg::ROLE_RIGHT;
        end else begin
            d_avail = mrct_pkg::ROLE_UNKNOWN;
        end
        d_found   = (r_cmd == mrct_pkg::CMD_LOOKUP) && r_found;
        d_nused_x = CMPW'(r_nused);
        if (d_nused_x >= CMPW'(r_limit)) begin
            d_total = r_limit;
        end else begin
            d_total = LW'(d_nused_x);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_mac        = r_mac;
        n_req        = r_req;
        n_limit      = r_limit;
        n_enabled    = r_enabled;
        n_cnt        = r_cnt;
        n_found      = r_found;
        n_match_idx  = r_match_idx;
        n_match_role = r_match_role;
        n_free_ok    = r_free_ok;
        n_free_idx   = r_free_idx;
        n_lo         = r_lo;
        n_ro         = r_ro;
        n_nused      = r_nused;
        n_wr         = r_wr;
        n_wr_idx     = r_wr_idx;
        n_total      = r_total;
        n_ecnt       = r_ecnt;
        n_avail      = r_avail;
        n_strobe     = 1'b0;
        n_result     = r_result;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd        = i_item.command;
                    n_mac        = i_item.client_mac;
                    n_req        = i_item.req_role;
                    n_limit      = (i_item.max_count > LIST_MAX) ? LIST_MAX : i_item.max_count;
                    n_cnt        = '0;
                    n_found      = 1'b0;
                    n_match_idx  = '0;
                    n_match_role = mrct_pkg::ROLE_UNKNOWN;
                    n_free_ok    = 1'b0;
                    n_free_idx   = '0;
                    n_lo         = 1'b0;
                    n_ro         = 1'b0;
                    n_nused      = '0;
                    n_wr         = 1'b0;
                    if (w_ctl.clr) begin
                        n_enabled = (i_item.command == mrct_pkg::CMD_INIT);
                        n_strobe  = 1'b1;
                        n_result  = '{status: mrct_pkg::ST_OK, found: 1'b0,
                                      role_out: mrct_pkg::ROLE_UNKNOWN,
                                      available_role: mrct_pkg::ROLE_LEFT,
                                      entry_mac: '0, entry_valid: 1'b0, last: 1'b1};
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_head_match && !r_found) begin
                    n_found      = 1'b1;
                    n_match_idx  = r_cnt;
                    n_match_role = w_head.role;
                end
                if (!w_head.used && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_cnt;
                end
                if (w_head.used && !w_head_match) begin
                    if (w_head.role == mrct_pkg::ROLE_LEFT) begin
                        n_lo = 1'b1;
                    end
                    if (w_head.role == mrct_pkg::ROLE_RIGHT) begin
                        n_ro = 1'b1;
                    end
                end
                if (w_head.used) begin
                    n_nused = r_nused + CW'(1);
                end
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DECIDE;
                end else begin
                    n_cnt = r_cnt + IW'(1);
                end
            end
            S_DECIDE: begin
                n_avail  = d_avail;
                n_wr     = d_wr;
                n_wr_idx = d_wr_idx;
                n_total  = d_total;
                n_ecnt   = '0;
                n_cnt    = '0;
                if (r_cmd == mrct_pkg::CMD_LIST) begin
                    if (d_total == '0) begin
                        n_strobe = 1'b1;
                        n_result = '{status: mrct_pkg::ST_OK, found: 1'b0,
                                     role_out: mrct_pkg::ROLE_UNKNOWN,
                                     available_role: d_avail,
                                     entry_mac: '0, entry_valid: 1'b0, last: 1'b1};
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_APPLY;
                    end
                end else begin
                    n_strobe = 1'b1;
                    n_result = '{status: d_status, found: d_found,
                                 role_out: d_found ? r_match_role : mrct_pkg::ROLE_UNKNOWN,
                                 available_role: d_avail,
                                 entry_mac: '0, entry_valid: 1'b0, last: 1'b1};
                    n_state  = d_wr ? S_APPLY : S_IDLE;
                end
            end
            S_APPLY: begin
                if (r_cmd == mrct_pkg::CMD_LIST && w_head.used && r_ecnt < r_total) begin
                    n_strobe = 1'b1;
                    n_result = '{status: mrct_pkg::ST_OK, found: 1'b0,
                                 role_out: w_head.role, available_role: r_avail,
                                 entry_mac: w_head.mac, entry_valid: 1'b1,
                                 last: (r_ecnt == r_total - LW'(1))};
                    n_ecnt   = r_ecnt + LW'(1);
                end
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_enabled <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_enabled <= n_enabled;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_mac        <= n_mac;
        r_req        <= n_req;
        r_limit      <= n_limit;
        r_cnt        <= n_cnt;
        r_found      <= n_found;
        r_match_idx  <= n_match_idx;
        r_match_role <= n_match_role;
        r_free_ok    <= n_free_ok;
        r_free_idx   <= n_free_idx;
        r_lo         <= n_lo;
        r_ro         <= n_ro;
        r_nused      <= n_nused;
        r_wr         <= n_wr;
        r_wr_idx     <= n_wr_idx;
        r_total      <= n_total;
        r_ecnt       <= n_ecnt;
        r_avail      <= n_avail;
        r_result     <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // every accepted item either keeps the block busy or answers right away
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted item neither busy nor answered");

    // only the final item of a list may leave the block idle behind it
    a_nonlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("non-final list item without pending work");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("strobe or busy right after reset");

endmodule
